// File: design/hrs_pkg.sv
// Shared types, character codes and constants of the HTTP response header scanner.
`default_nettype none
package hrs_pkg;

	// Largest number of bytes scanned in one buffer.
	localparam int unsigned BUFFER_BYTES = 2048;
	localparam int unsigned POS_W        = 16;
	localparam int unsigned FIELD_LEN    = 16;
	localparam int unsigned FIELD_IDX_W  = 4;

	// Widths of the result fields.
	localparam int unsigned DS_W  = 16;
	localparam int unsigned SC_W  = 10;
	localparam int unsigned CL_W  = 31;
	localparam int unsigned OUT_TDATA_W = 64;

	localparam logic [CL_W-1:0] LEN_MAX = {CL_W{1'b1}};

	// Character codes.
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_C     = 8'h43;

	// Field name searched for, one character per entry.
	localparam logic [7:0] FIELD_TEXT [FIELD_LEN] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
		8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
	};

	// Progress through a header end pattern.
	typedef enum logic [2:0] {
		END_NONE   = 3'd0,
		END_CR     = 3'd1,
		END_CRLF   = 3'd2,
		END_CRLFCR = 3'd3,
		END_LF     = 3'd4
	} end_prog_t;

	// Status code reading phase.
	typedef enum logic [2:0] {
		ST_NO_SPACE = 3'd0,
		ST_DIGIT1   = 3'd1,
		ST_DIGIT2   = 3'd2,
		ST_DIGIT3   = 3'd3,
		ST_DONE     = 3'd4
	} status_phase_t;

	// Content length reading phase.
	typedef enum logic [1:0] {
		LP_SEARCH = 2'd0,
		LP_DIGITS = 2'd1,
		LP_DONE   = 2'd2
	} length_phase_t;

	// One result word; data_start sits in the lowest bits.
	typedef struct packed {
		logic            length_saturated;
		logic [CL_W-1:0] content_length;
		logic [SC_W-1:0] status_code;
		logic [DS_W-1:0] data_start;
	} result_t;

endpackage
`default_nettype wire

// File: design/hrs_scan.sv
// Byte scanner: header end, status code and content length state with the final result.
`default_nettype none
module hrs_scan
	import hrs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	input  wire logic [7:0] rx_byte,
	input  wire logic       last_byte,
	output result_t         result
);

	logic [POS_W-1:0]       pos_q, pos_n;
	end_prog_t              end_prog_q, end_prog_n;
	logic [POS_W-1:0]       hdr_off_q, hdr_off_n;
	logic [POS_W-1:0]       hdr_start_q, hdr_start_n;
	status_phase_t          st_phase_q, st_phase_n;
	logic [POS_W-1:0]       st_start_q, st_start_n;
	logic [SC_W-1:0]        st_value_q, st_value_n;
	logic [FIELD_IDX_W-1:0] fld_idx_q, fld_idx_n;
	length_phase_t          len_phase_q, len_phase_n;
	logic [CL_W-1:0]        len_value_q, len_value_n;
	logic                   sat_q, sat_n;

	logic                   in_range;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [CL_W+3:0]        len_prod;
	logic [POS_W:0]         hdr_limit;
	logic [POS_W:0]         st_limit;
	logic [POS_W:0]         count_ext;

	// Next state for one byte.
	always_comb begin
		in_range    = pos_q < POS_W'(BUFFER_BYTES);
		is_digit    = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
		digit       = 4'(rx_byte - CHAR_ZERO);
		len_prod    = {4'd0, len_value_q} + {4'd0, len_value_q}
			+ {1'b0, len_value_q, 3'b000} + {4'd0, 27'd0, digit}
			+ {3'd0, len_value_q, 1'b0} - {4'd0, len_value_q} - {4'd0, len_value_q};

		pos_n       = pos_q;
		end_prog_n  = end_prog_q;
		hdr_off_n   = hdr_off_q;
		hdr_start_n = hdr_start_q;
		st_phase_n  = st_phase_q;
		st_start_n  = st_start_q;
		st_value_n  = st_value_q;
		fld_idx_n   = fld_idx_q;
		len_phase_n = len_phase_q;
		len_value_n = len_value_q;
		sat_n       = sat_q;

		if (in_range) begin
			pos_n = pos_q + 1'b1;

			// Header end: CR LF CR LF, CR LF LF or LF LF, first one only.
			if (hdr_off_q == '0) begin
				if (rx_byte == CHAR_CR) begin
					end_prog_n = (end_prog_q == END_CRLF) ? END_CRLFCR : END_CR;
				end else if (rx_byte == CHAR_LF) begin
					case (end_prog_q)
						END_CRLFCR: begin
							hdr_start_n = pos_q - POS_W'(3);
							hdr_off_n   = pos_q + 1'b1;
						end
						END_CRLF, END_LF: begin
							hdr_start_n = pos_q - 1'b1;
							hdr_off_n   = pos_q + 1'b1;
						end
						END_CR:  end_prog_n = END_CRLF;
						default: end_prog_n = END_LF;
					endcase
				end else begin
					end_prog_n = END_NONE;
				end
			end

			// Status code: up to three digits after the first space.
			case (st_phase_q)
				ST_NO_SPACE: begin
					if (rx_byte == CHAR_SPACE) begin
						st_phase_n = ST_DIGIT1;
						st_start_n = pos_q;
					end
				end
				ST_DIGIT1, ST_DIGIT2, ST_DIGIT3: begin
					if (is_digit) begin
						st_value_n = SC_W'({st_value_q, 3'b000} + {st_value_q, 1'b0}
							+ {9'd0, digit});
						st_phase_n = status_phase_t'(st_phase_q + 1'b1);
					end else begin
						st_phase_n = ST_DONE;
					end
				end
				default: ;
			endcase

			// Content length: match the field name, then read digits.
			case (len_phase_q)
				LP_SEARCH: begin
					if (rx_byte == FIELD_TEXT[fld_idx_q]) begin
						if (fld_idx_q == FIELD_IDX_W'(FIELD_LEN - 1)) begin
							len_phase_n = LP_DIGITS;
							fld_idx_n   = '0;
						end else begin
							fld_idx_n = fld_idx_q + 1'b1;
						end
					end else begin
						fld_idx_n = (rx_byte == CHAR_C) ? FIELD_IDX_W'(1) : '0;
					end
				end
				LP_DIGITS: begin
					if (is_digit) begin
						if (len_prod > {4'd0, LEN_MAX}) begin
							len_value_n = LEN_MAX;
							sat_n       = 1'b1;
						end else begin
							len_value_n = len_prod[CL_W-1:0];
						end
					end else begin
						len_phase_n = LP_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	// Result from the state after this byte.
	always_comb begin
		count_ext = {1'b0, pos_n};
		hdr_limit = {1'b0, hdr_start_n} + (POS_W+1)'(4);
		st_limit  = {1'b0, st_start_n} + (POS_W+1)'(4);

		result.data_start = (hdr_off_n != '0 && hdr_limit < count_ext) ? hdr_off_n : '0;
		result.status_code = (st_phase_n != ST_NO_SPACE && st_limit < count_ext)
			? st_value_n : '0;
		result.content_length   = len_value_n;
		result.length_saturated = sat_n;
	end

	// State registers; the last byte of a buffer returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			end_prog_q  <= END_NONE;
			hdr_off_q   <= '0;
			hdr_start_q <= '0;
			st_phase_q  <= ST_NO_SPACE;
			st_start_q  <= '0;
			st_value_q  <= '0;
			fld_idx_q   <= '0;
			len_phase_q <= LP_SEARCH;
			len_value_q <= '0;
			sat_q       <= 1'b0;
		end else if (byte_valid) begin
			if (last_byte) begin
				pos_q       <= '0;
				end_prog_q  <= END_NONE;
				hdr_off_q   <= '0;
				hdr_start_q <= '0;
				st_phase_q  <= ST_NO_SPACE;
				st_start_q  <= '0;
				st_value_q  <= '0;
				fld_idx_q   <= '0;
				len_phase_q <= LP_SEARCH;
				len_value_q <= '0;
				sat_q       <= 1'b0;
			end else begin
				pos_q       <= pos_n;
				end_prog_q  <= end_prog_n;
				hdr_off_q   <= hdr_off_n;
				hdr_start_q <= hdr_start_n;
				st_phase_q  <= st_phase_n;
				st_start_q  <= st_start_n;
				st_value_q  <= st_value_n;
				fld_idx_q   <= fld_idx_n;
				len_phase_q <= len_phase_n;
				len_value_q <= len_value_n;
				sat_q       <= sat_n;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/http_response_header_scanner.sv
// Top level of the HTTP response header scanner: input register, scanner and result register.
//
// The slave channel takes one byte of a response buffer per word, in order, with
// tlast on the final byte of the buffer. Only the buffer's first 2048 bytes are
// scanned; later bytes are taken and dropped, and tlast on one still closes it.
// The master channel gives one word per buffer, after its last byte: data start
// offset (0 without a header end), status code, content length and the
// saturation flag.
// One byte is taken in every cycle while no closing byte waits. A byte sits in the input
// register and is scanned on its way out. The result word is registered when its
// last byte leaves the input register, and then shows on m_axis_tvalid.
// While a result waits on the master side, bytes that do not close a buffer keep
// flowing; a closing byte waits in the input register, and then s_axis_tready
// drops, until the waiting result is taken.
// Reset clears the scanner state, the input register and the result register's
// valid flag; the block takes bytes in the first cycle after reset.
`default_nettype none
module http_response_header_scanner
	import hrs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
	input  wire logic                   s_axis_tlast,   // last_byte
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// [15:0] data_start, [25:16] status_code, [56:26] content_length,
	// [57] length_saturated, [63:58] zero
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance_s1;
	logic       out_free;
	logic       out_valid_q;
	result_t    result_q;
	result_t    scan_result;

	// Handshake between the input register and the result register.
	always_comb begin
		out_free      = !out_valid_q || m_axis_tready;
		advance_s1    = valid_s1 && (!last_s1 || out_free);
		s_axis_tready = !valid_s1 || advance_s1;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	hrs_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (advance_s1),
		.rx_byte    (byte_s1),
		.last_byte  (last_s1),
		.result     (scan_result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			result_q <= scan_result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), result_q};

endmodule
`default_nettype wire

// File: design/hrs_checker.sv
// Port checker for the HTTP response header scanner, bound to the top level.
`default_nettype none
module hrs_checker
	import hrs_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   s_axis_tlast,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// A header end is at least LF LF, so a found data start is at least two.
	a_ds_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[15:0] != '0 |-> m_axis_tdata[15:0] >= 16'd2)
		else $error("data start below two");

	// Status code holds at most three decimal digits.
	a_sc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[25:16] <= 10'd999)
		else $error("status code out of range");

	// A saturated length reads as the largest value.
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[57] |-> m_axis_tdata[56:26] == LEN_MAX)
		else $error("saturated length not at maximum");

	// A fresh result word follows a closing byte taken on the slave side.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
		else $error("result word appeared without a closing byte");

endmodule

bind http_response_header_scanner hrs_checker u_hrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the HTTP response header scanner, with a byte-level scan model.
module testbench;
	import hrs_pkg::*;

	localparam int QUIET_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_BYTES   = 200;
	localparam int PHASE_BUFS    = 5;
	localparam int SEND_IDLE  [4] = '{0, 65, 0, 38};
	localparam int RECV_STALL [4] = '{0, 0, 65, 38};

	// Directed buffers. A row either carries its expected header word or leaves it to the model.
	typedef struct packed {
		bit      typed;
		result_t want;
	} dir_check_t;

	localparam dir_check_t BY_MODEL  = '0;
	localparam dir_check_t ALL_ZERO  = {1'b1, 58'd0};
	// Order: typed, length_saturated, content_length, status_code, data_start.
	localparam dir_check_t SATURATED = {1'b1, 1'b1, LEN_MAX, 10'd999, 16'd0};
	localparam int DIR_ROWS = 15;

	string dir_text [DIR_ROWS] = '{
		"\001",
		"\377",
		"HTTP/1.1 200 OK\015\012Content-Length: 42\015\012\015\012body",
		"HTTP/1.0 404 Not Found\012\012",
		"HTTP/1.0 301\012\012abcd",
		"Content-Length: 99999999999\015\012",
		"Content-Length: 2147483647\012\012xxxx",
		"HTTP/1.1 2x0 OK\015\012Content-Length: 1a5\015\012\015\012zz",
		"HTTP/1.1 99\015\012Content-Length: 123",
		"ABCDE 200",
		"\015\012\015\015\012\015\012abcd",
		"CContent-Length: 7\012\012abcd",
		"Content-Length:  5\012\012abcd",
		"HTTP/1.1 \015\012\015\012abcd",
		"\015\015\012\012xxxxx"
	};
	dir_check_t dir_check [DIR_ROWS] = '{
		ALL_ZERO, ALL_ZERO, BY_MODEL, BY_MODEL, BY_MODEL,
		SATURATED, BY_MODEL, BY_MODEL, BY_MODEL, ALL_ZERO,
		BY_MODEL, BY_MODEL, BY_MODEL, BY_MODEL, BY_MODEL
	};

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata  = 8'd0;   // [7:0] rx_byte
	logic                   s_axis_tlast  = 1'b0;   // last_byte
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// [15:0] data_start, [25:16] status_code, [56:26] content_length,
	// [57] length_saturated, [63:58] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	http_response_header_scanner i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Scan state of the model.
	logic [POS_W-1:0] scan_pos;
	logic [POS_W-1:0] hdr_end_off;
	logic [POS_W-1:0] hdr_end_start;
	logic [POS_W-1:0] status_pos;
	end_prog_t        end_prog;
	status_phase_t    status_phase;
	logic [SC_W-1:0]  status_val;
	int unsigned      field_idx;
	length_phase_t    len_phase;
	logic [CL_W-1:0]  len_val;
	logic             len_sat;

	result_t    header_results_due [$];
	logic [7:0] frame [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int mismatches    = 0;
	int results_seen  = 0;
	int bytes_sent    = 0;
	int buffers_sent  = 0;
	int overlong_sent = 0;
	int quiet_cycles  = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void clear_scan();
		scan_pos      = '0;
		hdr_end_off   = '0;
		hdr_end_start = '0;
		status_pos    = '0;
		end_prog      = END_NONE;
		status_phase  = ST_NO_SPACE;
		status_val    = '0;
		field_idx     = 0;
		len_phase     = LP_SEARCH;
		len_val       = '0;
		len_sat       = 1'b0;
	endfunction

	// Advance the scan by one byte; returns 1 with the header word when the buffer closes.
	function automatic bit scan_byte(input logic [7:0] b, input logic lst, output result_t res);
		int unsigned    p;
		int unsigned    cnt;
		longint unsigned acc;
		bit             digit;
		res = '0;
		digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		if (scan_pos < BUFFER_BYTES) begin
			p = scan_pos;
			// Header end search, frozen once the first one is found.
			if (hdr_end_off == '0) begin
				if (b == CHAR_CR) begin
					end_prog = (end_prog == END_CRLF) ? END_CRLFCR : END_CR;
				end else if (b == CHAR_LF) begin
					if (end_prog == END_CRLFCR) begin
						hdr_end_start = POS_W'(p - 3);
						hdr_end_off   = POS_W'(p + 1);
					end else if (end_prog == END_CRLF || end_prog == END_LF) begin
						hdr_end_start = POS_W'(p - 1);
						hdr_end_off   = POS_W'(p + 1);
					end else if (end_prog == END_CR) begin
						end_prog = END_CRLF;
					end else begin
						end_prog = END_LF;
					end
				end else begin
					end_prog = END_NONE;
				end
			end
			// Status code: up to three digits after the first space.
			if (status_phase == ST_NO_SPACE) begin
				if (b == CHAR_SPACE) begin
					status_phase = ST_DIGIT1;
					status_pos   = POS_W'(p);
				end
			end else if (status_phase != ST_DONE) begin
				if (digit) begin
					status_val   = SC_W'(status_val * 10 + (b - CHAR_ZERO));
					status_phase = status_phase_t'(status_phase + 1);
				end else begin
					status_phase = ST_DONE;
				end
			end
			// Content length field name match, then its digits.
			if (len_phase == LP_SEARCH) begin
				if (b == FIELD_TEXT[field_idx])
					field_idx++;
				else
					field_idx = (b == CHAR_C) ? 1 : 0;
				if (field_idx >= FIELD_LEN) begin
					len_phase = LP_DIGITS;
					field_idx = 0;
				end
			end else if (len_phase == LP_DIGITS) begin
				if (digit) begin
					acc = 64'(len_val) * 10 + 64'(b - CHAR_ZERO);
					if (acc > LEN_MAX) begin
						acc     = LEN_MAX;
						len_sat = 1'b1;
					end
					len_val = CL_W'(acc);
				end else begin
					len_phase = LP_DONE;
				end
			end
			scan_pos = POS_W'(p + 1);
		end
		if (!lst)
			return 1'b0;
		cnt = scan_pos;
		if (hdr_end_off != '0 && hdr_end_start + 4 < cnt)
			res.data_start = hdr_end_off;
		if (status_phase != ST_NO_SPACE && status_pos + 4 < cnt)
			res.status_code = status_val;
		res.content_length   = len_val;
		res.length_saturated = len_sat;
		clear_scan();
		return 1'b1;
	endfunction

	// Compare one header word from the block with the oldest expectation.
	task automatic compare_header_word(input logic [OUT_TDATA_W-1:0] word);
		result_t got;
		result_t want;
		got = word[$bits(result_t)-1:0];
		results_seen++;
		if (header_results_due.size() == 0) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: header word %h with nothing expected", $realtime, word);
			mismatches++;
			return;
		end
		want = header_results_due.pop_front();
		if (got.data_start !== want.data_start || got.status_code !== want.status_code ||
				got.content_length !== want.content_length ||
				got.length_saturated !== want.length_saturated ||
				word[OUT_TDATA_W-1:$bits(result_t)] !== '0) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: expected ds=%0d sc=%0d cl=%0d sat=%0b, got ds=%0d sc=%0d cl=%0d sat=%0b pad=%h",
					$realtime, want.data_start, want.status_code, want.content_length,
					want.length_saturated, got.data_start, got.status_code,
					got.content_length, got.length_saturated,
					word[OUT_TDATA_W-1:$bits(result_t)]);
			mismatches++;
		end
	endtask

	// Result side: check accepted words and stall at random.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			compare_header_word(m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Cycles in which no word moves on either side.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("No word moved in %0d cycles.", QUIET_LIMIT);
		$display("http_response_header_scanner: mismatch");
		$finish;
	end

	function automatic logic [7:0] any_byte();
		case ($urandom_range(9))
			0: return CHAR_CR;
			1: return CHAR_LF;
			2: return CHAR_SPACE;
			3: return CHAR_ZERO + 8'($urandom_range(9));
			4: return $urandom_range(1) ? 8'h00 : 8'hFF;
			5: return CHAR_C;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			frame.push_back(s[i]);
	endtask

	task automatic add_eol(input bit lf_only);
		if (!lf_only)
			frame.push_back(CHAR_CR);
		frame.push_back(CHAR_LF);
	endtask

	task automatic add_digits(input int n);
		repeat (n) frame.push_back(CHAR_ZERO + 8'($urandom_range(9)));
	endtask

	// A plausible response head with random content; overlong ones pad past the scan limit.
	task automatic build_response(input bit overlong);
		bit lf_only;
		int target;
		int keep;
		frame.delete();
		lf_only = ($urandom_range(2) == 0);
		add_text($urandom_range(1) ? "HTTP/1.1 " : "HTTP/1.0 ");
		add_digits($urandom_range(0, 4));
		if ($urandom_range(4) == 0)
			frame.push_back(any_byte());
		add_text(" OK");
		add_eol(lf_only);
		if ($urandom_range(3) == 0) begin
			add_text("Server: x");
			add_eol(lf_only);
		end
		if ($urandom_range(3) == 0) begin
			add_text($urandom_range(1) ? "Content-Lengt: 9" : "content-length: 9");
			add_eol(lf_only);
		end
		if (overlong) begin
			target = $urandom_range(2000, 2040);
			add_text("X-Fill: ");
			while (frame.size() < target)
				frame.push_back(8'h61 + 8'($urandom_range(25)));   // lowercase letter
			add_eol(lf_only);
		end
		if ($urandom_range(4) != 0) begin
			add_text("Content-Length: ");
			add_digits(($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 6));
			if ($urandom_range(5) == 0)
				frame.push_back(any_byte());
			add_eol(lf_only);
		end
		add_eol(lf_only);
		repeat ($urandom_range(0, 16)) frame.push_back(any_byte());
		if (overlong) begin
			target = BUFFER_BYTES + 1 + $urandom_range(0, 12);
			while (frame.size() < target)
				frame.push_back(any_byte());
		end else begin
			// Broken responses: a stray byte, a cut short buffer.
			if ($urandom_range(4) == 0)
				frame[$urandom_range(frame.size() - 1)] = any_byte();
			if ($urandom_range(9) == 0) begin
				keep = $urandom_range(1, frame.size());
				frame = frame[0:keep-1];
			end
		end
	endtask

	// Offer one byte and wait for its handshake, with random gaps before it.
	task automatic send_byte(input logic [7:0] b, input logic lst, input dir_check_t chk);
		result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= lst;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		if (scan_byte(b, lst, res))
			header_results_due.push_back(chk.typed ? chk.want : res);
	endtask

	task automatic send_frame(input dir_check_t chk);
		for (int i = 0; i < frame.size(); i++)
			send_byte(frame[i], i == frame.size() - 1, chk);
		buffers_sent++;
		if (frame.size() > BUFFER_BYTES)
			overlong_sent++;
	endtask

	// Hold the sender off until every header word has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (header_results_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int phase_bytes;
		int phase_bufs;
		clear_scan();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed buffers, no idling.
		for (int r = 0; r < DIR_ROWS; r++) begin
			frame.delete();
			add_text(dir_text[r]);
			send_frame(dir_check[r]);
		end
		drain();

		// Random buffers in four idling phases; one overlong buffer under receiver stalls.
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			stall_pct     = RECV_STALL[ph];
			phase_bytes   = 0;
			phase_bufs    = 0;
			while (phase_bytes < PHASE_BYTES || phase_bufs < PHASE_BUFS) begin
				if (ph == 2 && phase_bufs == 3) begin
					build_response(1'b1);
				end else if ($urandom_range(99) < 80) begin
					build_response(1'b0);
				end else begin
					frame.delete();
					repeat ($urandom_range(1, 40)) frame.push_back(any_byte());
				end
				if (frame.size() <= BUFFER_BYTES)
					phase_bytes += frame.size();
				phase_bufs++;
				send_frame(BY_MODEL);
			end
			drain();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Scanned %0d buffers of %0d bytes in all, %0d of them past the %0d-byte limit.",
			buffers_sent, bytes_sent, overlong_sent, BUFFER_BYTES);
		$display("Checked %0d header words under four idling phases; %0d mismatches.",
			results_seen, mismatches);
		if (mismatches == 0 && header_results_due.size() == 0)
			$display("http_response_header_scanner: match");
		else
			$display("http_response_header_scanner: mismatch");
		$finish;
	end

endmodule
